// ===== rtl/gha_pkg.sv =====
// shared types and constants for the generational handle allocator
package gha_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int GEN_W       = 16;
    localparam int IDX_W       = 16;
    localparam int CAP_W       = 11;
    localparam int IN_TDATA_W  = ((IDX_W + GEN_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = SLOT_W + GEN_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_SLOT    = 2'd1,
        STATUS_BAD_HANDLE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_STK,
        ST_ALLOC_GEN,
        ST_HANDLE,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   index;
        logic [GEN_W-1:0]    generation;
        logic                valid;
    } result_t;

    typedef struct packed {
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_addr;
        logic [GEN_W-1:0]    wr_data;
        logic                rd_en;
        logic [SLOT_W-1:0]   rd_addr;
    } gen_ram_req_t;

    typedef struct packed {
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_addr;
        logic [SLOT_W-1:0]   wr_data;
        logic                rd_en;
        logic [SLOT_W-1:0]   rd_addr;
    } slot_ram_req_t;

endpackage

// ===== rtl/gha_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read
module gha_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gha_ctrl.sv =====
// request sequencer: stack and generation bookkeeping, drain and clearing pass
module gha_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gha_pkg::CAP_W-1:0]           cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [gha_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output gha_pkg::result_t                    m_result,
    output gha_pkg::gen_ram_req_t               gen_req,
    input  logic [gha_pkg::GEN_W-1:0]           gen_rd_data,
    output gha_pkg::slot_ram_req_t              stk_req,
    input  logic [gha_pkg::SLOT_W-1:0]          stk_rd_data,
    output gha_pkg::slot_ram_req_t              pend_req,
    input  logic [gha_pkg::SLOT_W-1:0]          pend_rd_data
);

    localparam logic [gha_pkg::CNT_W-1:0] MAX_CNT = gha_pkg::CNT_W'(gha_pkg::MAX_SLOTS);

    gha_pkg::state_t                 state_reg, state_next;
    logic [gha_pkg::CNT_W-1:0]       cap_reg, cap_next;
    logic [gha_pkg::CNT_W-1:0]       free_cnt_reg, free_cnt_next;
    logic [gha_pkg::CNT_W-1:0]       low_reg, low_next;
    logic [gha_pkg::CNT_W-1:0]       pend_cnt_reg, pend_cnt_next;
    logic [gha_pkg::CNT_W-1:0]       drain_k_reg, drain_k_next;
    logic                            drain_pipe_reg, drain_pipe_next;
    logic [gha_pkg::SLOT_W-1:0]      clr_reg, clr_next;
    gha_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [gha_pkg::SLOT_W-1:0]      idx_reg, idx_next;
    logic [gha_pkg::GEN_W-1:0]       hgen_reg, hgen_next;
    logic                            in_range_reg, in_range_next;
    logic                            fail_reg, fail_next;
    logic                            orig_reg, orig_next;
    logic [gha_pkg::SLOT_W-1:0]      stk_addr_reg, stk_addr_next;
    logic [gha_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic                            m_valid_reg, m_valid_next;
    gha_pkg::result_t                m_res_reg, m_res_next;
    gha_pkg::result_t                hold_reg, hold_next;

    logic [gha_pkg::IDX_W-1:0]       s_idx;
    logic [gha_pkg::GEN_W-1:0]       s_gen;
    logic [gha_pkg::CNT_W-1:0]       pop_addr;
    logic [gha_pkg::SLOT_W-1:0]      slot_sel;
    logic [gha_pkg::CNT_W-1:0]       cap_sat;
    logic                            handle_ok;
    logic                            drain_issue;
    logic                            done;
    logic                            out_free;
    gha_pkg::result_t                res;

    assign s_idx    = s_axis_tdata[gha_pkg::IDX_W-1:0];
    assign s_gen    = s_axis_tdata[gha_pkg::IDX_W +: gha_pkg::GEN_W];
    assign pop_addr = free_cnt_reg - gha_pkg::CNT_W'(1);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign cap_sat  = (int'(cfg_wr_data) > gha_pkg::MAX_SLOTS) ? MAX_CNT
                                                               : gha_pkg::CNT_W'(cfg_wr_data);

    // stack entries below the low-water mark were never overwritten, entry i holds i
    assign slot_sel    = orig_reg ? stk_addr_reg : stk_rd_data;
    assign handle_ok   = in_range_reg && (gen_rd_data == hgen_reg);
    assign drain_issue = drain_k_reg < pend_cnt_reg;

    assign s_axis_tready = (state_reg == gha_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_result      = m_res_reg;

    always_comb begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        free_cnt_next   = free_cnt_reg;
        low_next        = low_reg;
        pend_cnt_next   = pend_cnt_reg;
        drain_k_next    = drain_k_reg;
        drain_pipe_next = 1'b0;
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        hgen_next       = hgen_reg;
        in_range_next   = in_range_reg;
        fail_next       = fail_reg;
        orig_next       = orig_reg;
        stk_addr_next   = stk_addr_reg;
        slot_next       = slot_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_res_next      = m_res_reg;
        hold_next       = hold_reg;
        gen_req         = '0;
        stk_req         = '0;
        pend_req        = '0;
        res             = '0;
        res.status      = gha_pkg::STATUS_OK;
        done            = 1'b0;

        unique case (state_reg)
            gha_pkg::ST_CLEAR: begin
                gen_req.wr_en   = 1'b1;
                gen_req.wr_addr = clr_reg;
                gen_req.wr_data = '0;
                clr_next        = clr_reg + gha_pkg::SLOT_W'(1);
                if (clr_reg == gha_pkg::SLOT_W'(gha_pkg::MAX_SLOTS - 1)) begin
                    state_next = gha_pkg::ST_IDLE;
                end
            end
            gha_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd_next      = gha_pkg::cmd_t'(s_axis_tuser);
                    idx_next      = s_idx[gha_pkg::SLOT_W-1:0];
                    hgen_next     = s_gen;
                    in_range_next = 32'(s_idx) < 32'(cap_reg);
                    fail_next     = (free_cnt_reg == '0);
                    unique case (gha_pkg::cmd_t'(s_axis_tuser))
                        gha_pkg::CMD_ALLOC: begin
                            if (free_cnt_reg != '0) begin
                                stk_req.rd_en   = 1'b1;
                                stk_req.rd_addr = pop_addr[gha_pkg::SLOT_W-1:0];
                                orig_next       = pop_addr < low_reg;
                                stk_addr_next   = pop_addr[gha_pkg::SLOT_W-1:0];
                                free_cnt_next   = pop_addr;
                                if (pop_addr < low_reg) begin
                                    low_next = pop_addr;
                                end
                            end
                            state_next = gha_pkg::ST_ALLOC_STK;
                        end
                        gha_pkg::CMD_DESTROY, gha_pkg::CMD_CHECK: begin
                            gen_req.rd_en   = 1'b1;
                            gen_req.rd_addr = s_idx[gha_pkg::SLOT_W-1:0];
                            state_next      = gha_pkg::ST_HANDLE;
                        end
                        gha_pkg::CMD_TICK: begin
                            drain_k_next = '0;
                            state_next   = gha_pkg::ST_DRAIN;
                        end
                        default: begin
                            state_next = gha_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            gha_pkg::ST_ALLOC_STK: begin
                if (fail_reg) begin
                    res.status = gha_pkg::STATUS_NO_SLOT;
                    done       = 1'b1;
                end else begin
                    gen_req.rd_en   = 1'b1;
                    gen_req.rd_addr = slot_sel;
                    slot_next       = slot_sel;
                    state_next      = gha_pkg::ST_ALLOC_GEN;
                end
            end
            gha_pkg::ST_ALLOC_GEN: begin
                res.index      = slot_reg;
                res.generation = gen_rd_data;
                done           = 1'b1;
            end
            gha_pkg::ST_HANDLE: begin
                res.valid = handle_ok;
                if (cmd_reg == gha_pkg::CMD_DESTROY) begin
                    if (handle_ok) begin
                        gen_req.wr_en   = 1'b1;
                        gen_req.wr_addr = idx_reg;
                        gen_req.wr_data = gen_rd_data + gha_pkg::GEN_W'(1);
                        // a full pending list drops the index but the request still succeeds
                        if (pend_cnt_reg < MAX_CNT) begin
                            pend_req.wr_en   = 1'b1;
                            pend_req.wr_addr = pend_cnt_reg[gha_pkg::SLOT_W-1:0];
                            pend_req.wr_data = idx_reg;
                            pend_cnt_next    = pend_cnt_reg + gha_pkg::CNT_W'(1);
                        end
                    end else begin
                        res.status = gha_pkg::STATUS_BAD_HANDLE;
                    end
                end
                done = 1'b1;
            end
            gha_pkg::ST_DRAIN: begin
                if (drain_issue) begin
                    pend_req.rd_en   = 1'b1;
                    pend_req.rd_addr = drain_k_reg[gha_pkg::SLOT_W-1:0];
                    drain_k_next     = drain_k_reg + gha_pkg::CNT_W'(1);
                    drain_pipe_next  = 1'b1;
                end
                // pending entry read last cycle goes onto the stack if there is room
                if (drain_pipe_reg && (free_cnt_reg < MAX_CNT)) begin
                    stk_req.wr_en   = 1'b1;
                    stk_req.wr_addr = free_cnt_reg[gha_pkg::SLOT_W-1:0];
                    stk_req.wr_data = pend_rd_data;
                    free_cnt_next   = free_cnt_reg + gha_pkg::CNT_W'(1);
                end
                if (!drain_issue && !drain_pipe_reg) begin
                    pend_cnt_next = '0;
                    done          = 1'b1;
                end
            end
            gha_pkg::ST_OUT: begin
                if (out_free) begin
                    m_res_next   = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = gha_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gha_pkg::ST_IDLE;
            end
        endcase

        if (done) begin
            if (out_free) begin
                m_res_next   = res;
                m_valid_next = 1'b1;
                state_next   = gha_pkg::ST_IDLE;
            end else begin
                hold_next  = res;
                state_next = gha_pkg::ST_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gha_pkg::ST_CLEAR;
            cap_reg        <= MAX_CNT;
            free_cnt_reg   <= MAX_CNT;
            low_reg        <= MAX_CNT;
            pend_cnt_reg   <= '0;
            drain_k_reg    <= '0;
            drain_pipe_reg <= 1'b0;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            // capacity write restarts the store and its clearing pass
            state_reg      <= gha_pkg::ST_CLEAR;
            cap_reg        <= cap_sat;
            free_cnt_reg   <= cap_sat;
            low_reg        <= cap_sat;
            pend_cnt_reg   <= '0;
            drain_k_reg    <= '0;
            drain_pipe_reg <= 1'b0;
            clr_reg        <= '0;
            m_valid_reg    <= m_valid_next;
        end else begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            free_cnt_reg   <= free_cnt_next;
            low_reg        <= low_next;
            pend_cnt_reg   <= pend_cnt_next;
            drain_k_reg    <= drain_k_next;
            drain_pipe_reg <= drain_pipe_next;
            clr_reg        <= clr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        hgen_reg     <= hgen_next;
        in_range_reg <= in_range_next;
        fail_reg     <= fail_next;
        orig_reg     <= orig_next;
        stk_addr_reg <= stk_addr_next;
        slot_reg     <= slot_next;
        m_res_reg    <= m_res_next;
        hold_reg     <= hold_next;
    end

`ifndef SYNTHESIS
    a_free_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= MAX_CNT)
        else $error("free count above slot count");

    a_low_water: assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= free_cnt_reg)
        else $error("low-water mark above free count");

    a_pend_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg <= MAX_CNT)
        else $error("pending count above slot count");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gha_pkg::ST_DRAIN && !drain_issue && !drain_pipe_reg)
        |=> (pend_cnt_reg == '0))
        else $error("pending list not empty after tick");

    a_hold_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gha_pkg::ST_OUT) |-> m_valid_reg)
        else $error("result held back while output register is free");
`endif

endmodule

// ===== rtl/generational_handle_allocator.sv =====
// Generational handle allocator: one request at a time, state in three synchronous rams.
// Check and destroy do one generation ram read-modify-write. Allocate reads the free stack and
// then the generation ram at the popped index, which depends on that stack read. A tick moves
// each pending destroy onto the free stack, one entry a cycle through the pending ram read port.
// After reset and after every capacity write a clearing pass zeroes the generation ram, during
// which no request is accepted. A finished result waits in the output register while the next
// request is taken.
module generational_handle_allocator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [gha_pkg::CAP_W-1:0]            cfg_wr_data,   // capacity
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [gha_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // slot_index, handle_generation
    input  logic [1:0]                           s_axis_tuser,  // command
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // given_index, given_generation, handle_valid, zero padding
    output logic [gha_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                           m_axis_tuser   // status
);

    gha_pkg::result_t                 m_result;
    gha_pkg::gen_ram_req_t            gen_req;
    gha_pkg::slot_ram_req_t           stk_req;
    gha_pkg::slot_ram_req_t           pend_req;
    logic [gha_pkg::GEN_W-1:0]        gen_rd_data;
    logic [gha_pkg::SLOT_W-1:0]       stk_rd_data;
    logic [gha_pkg::SLOT_W-1:0]       pend_rd_data;

    gha_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_result      (m_result),
        .gen_req       (gen_req),
        .gen_rd_data   (gen_rd_data),
        .stk_req       (stk_req),
        .stk_rd_data   (stk_rd_data),
        .pend_req      (pend_req),
        .pend_rd_data  (pend_rd_data)
    );

    // generation per slot
    gha_ram #(
        .DEPTH (gha_pkg::MAX_SLOTS),
        .WIDTH (gha_pkg::GEN_W)
    ) u_gen_ram (
        .aclk    (aclk),
        .wr_en   (gen_req.wr_en),
        .wr_addr (gen_req.wr_addr),
        .wr_data (gen_req.wr_data),
        .rd_en   (gen_req.rd_en),
        .rd_addr (gen_req.rd_addr),
        .rd_data (gen_rd_data)
    );

    // free index stack
    gha_ram #(
        .DEPTH (gha_pkg::MAX_SLOTS),
        .WIDTH (gha_pkg::SLOT_W)
    ) u_stk_ram (
        .aclk    (aclk),
        .wr_en   (stk_req.wr_en),
        .wr_addr (stk_req.wr_addr),
        .wr_data (stk_req.wr_data),
        .rd_en   (stk_req.rd_en),
        .rd_addr (stk_req.rd_addr),
        .rd_data (stk_rd_data)
    );

    // pending destroy list
    gha_ram #(
        .DEPTH (gha_pkg::MAX_SLOTS),
        .WIDTH (gha_pkg::SLOT_W)
    ) u_pend_ram (
        .aclk    (aclk),
        .wr_en   (pend_req.wr_en),
        .wr_addr (pend_req.wr_addr),
        .wr_data (pend_req.wr_data),
        .rd_en   (pend_req.rd_en),
        .rd_addr (pend_req.rd_addr),
        .rd_data (pend_rd_data)
    );

    assign m_axis_tdata = {{(gha_pkg::OUT_TDATA_W - gha_pkg::OUT_FIELD_W){1'b0}},
                           m_result.valid, m_result.generation, m_result.index};
    assign m_axis_tuser = m_result.status;

endmodule
